// ----- rtl/core/hpq_pkg.sv -----
// Shared types and codes for the binary heap priority queue.
package hpq_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_LAST,
        S_DOWN,
        S_PUT,
        S_TOP_RD,
        S_FIN
    } t_state;

    // compare unit decision
    typedef struct packed {
        logic up_move;     // moving entry beats its parent
        logic down_move;   // a child beats the moving entry
        logic down_right;  // the winning child is the right one
    } t_sel;

endpackage

// ----- rtl/core/binary_heap_priority_queue_core.sv -----
// Binary heap priority queue core: heap in one RAM, sift walk by a small sequencer.
// Steps: insert walks up in S_UP (skipped on an empty heap), delete reads the last entry
//   in S_LAST and walks down in S_DOWN, each at most floor(log2(CAPACITY)) levels; then
//   S_PUT, S_TOP_RD and S_FIN; a dropped insert or delete on empty or of the last entry
//   goes straight to S_TOP_RD. No new command is accepted until back in S_IDLE.
// Reset (sync, active low): count cleared, max-heap order, no result; RAM not cleared.
module binary_heap_priority_queue_core
    import hpq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [VALUE_WIDTH-1:0] i_value,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_WIDTH-1:0] o_top_value,
    output logic                   o_is_empty,
    output logic [CW-1:0]          o_entry_count,
    output logic [1:0]             o_status,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_max_mode
);

    localparam int AW = $clog2(CAPACITY);     // heap slot index
    localparam int XW = AW + 2;                // child index incl. overflow

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_pos, n_pos;          // hole being walked
    logic [VALUE_WIDTH-1:0] r_cur, n_cur;          // entry being sifted
    logic [1:0]             r_status, n_status;
    logic                   r_max_mode;

    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_top, n_out_top;
    logic                   r_out_empty, n_out_empty;
    logic [CW-1:0]          r_out_count, n_out_count;
    logic [1:0]             r_out_status, n_out_status;

    // RAM port
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [AW-1:0]          w_raddr_a, w_raddr_b;
    logic [VALUE_WIDTH-1:0] w_rdata_a, w_rdata_b;

    // index helpers
    logic                   w_in_acc;
    logic [CW-1:0]          w_cnt_m1;
    logic [AW-1:0]          w_cnt_par;     // parent of slot count
    logic [AW-1:0]          w_up;          // parent of r_pos
    logic [AW-1:0]          w_upup;        // parent of w_up
    logic [XW-1:0]          w_lidx, w_ridx;
    logic                   w_left_ok, w_right_ok;
    logic [AW-1:0]          w_child;
    t_sel                   w_sel;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_cnt_par = AW'(w_cnt_m1 >> 1);
    assign w_up      = (r_pos - AW'(1)) >> 1;
    assign w_upup    = (w_up - AW'(1)) >> 1;
    assign w_lidx    = {1'b0, r_pos, 1'b1};
    assign w_ridx    = {1'b0, r_pos, 1'b0} + XW'(2);
    assign w_left_ok  = w_lidx < XW'(r_count);
    assign w_right_ok = w_ridx < XW'(r_count);
    assign w_child   = w_sel.down_right ? AW'(w_ridx) : AW'(w_lidx);

    // ---------------------------------------------------------------
    // heap store and compare unit
    // ---------------------------------------------------------------
    hpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_hpq_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // on sift up port A holds the parent, on sift down the left child
    hpq_sel #(
        .W (VALUE_WIDTH)
    ) u_hpq_sel (
        .i_max_mode (r_max_mode),
        .i_cur      (r_cur),
        .i_left     (w_rdata_a),
        .i_right    (w_rdata_b),
        .i_left_ok  (w_left_ok),
        .i_right_ok (w_right_ok),
        .o_sel      (w_sel)
    );

    // ---------------------------------------------------------------
    // sequencer
    // The moving entry is held in r_cur and only written once at its
    // final slot; each level writes the displaced neighbor into the hole.
    // The write of one level and the read of the next never hit the same
    // slot (parent vs. grandparent, parent vs. children), so no
    // forwarding is needed. The final root read follows all writes.
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_top    = r_out_top;
        n_out_empty  = r_out_empty;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_cur;
        w_raddr_a    = '0;
        w_raddr_b    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_status = ST_DONE;
                    n_cur    = i_value;
                    if (i_command == CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_TOP_RD;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_pos   = AW'(r_count);
                            if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                w_raddr_a = w_cnt_par;
                                n_state   = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_TOP_RD;
                        end else begin
                            n_count = w_cnt_m1;
                            if (w_cnt_m1 == '0) begin
                                n_state = S_TOP_RD;
                            end else begin
                                w_raddr_a = AW'(w_cnt_m1);   // last entry
                                n_state   = S_LAST;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                if (w_sel.up_move) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata_a;
                    n_pos   = w_up;
                    if (w_up == '0) begin
                        n_state = S_PUT;
                    end else begin
                        w_raddr_a = w_upup;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_LAST: begin
                n_cur     = w_rdata_a;
                n_pos     = '0;
                w_raddr_a = AW'(1);
                w_raddr_b = AW'(2);
                n_state   = S_DOWN;
            end
            S_DOWN: begin
                if (w_sel.down_move) begin
                    w_we      = 1'b1;
                    w_wdata   = w_sel.down_right ? w_rdata_b : w_rdata_a;
                    n_pos     = w_child;
                    w_raddr_a = AW'({1'b0, w_child, 1'b1});
                    w_raddr_b = AW'({1'b0, w_child, 1'b0} + XW'(2));
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                n_state = S_TOP_RD;
            end
            S_TOP_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // read address stays at the root, so data holds while waiting
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = (r_count == '0) ? '1 : w_rdata_a;
                    n_out_empty  = (r_count == '0);
                    n_out_count  = r_count;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_mode  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_mode <= i_cfg_max_mode;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_status     <= n_status;
        r_out_top    <= n_out_top;
        r_out_empty  <= n_out_empty;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // ---------------------------------------------------------------
    // ports
    // ---------------------------------------------------------------
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

// ----- rtl/core/hpq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read of the address being written returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/core/hpq_sel.sv -----
// Ordering compare and child selection for sift up and sift down.
module hpq_sel
    import hpq_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_max_mode,
    input  logic [W-1:0] i_cur,
    input  logic [W-1:0] i_left,   // parent on sift up, left child on sift down
    input  logic [W-1:0] i_right,
    input  logic         i_left_ok,
    input  logic         i_right_ok,
    output t_sel         o_sel
);

    // strict ordering: a sits above b
    function automatic logic better(input logic [W-1:0] a, input logic [W-1:0] b,
                                    input logic mode);
        logic gt;
        logic lt;
        gt = $signed(a) > $signed(b);
        lt = $signed(a) < $signed(b);
        return mode ? gt : lt;
    endfunction

    logic         w_left_wins;
    logic [W-1:0] w_best;

    always_comb begin
        w_left_wins = i_left_ok && better(i_left, i_cur, i_max_mode);
        w_best      = w_left_wins ? i_left : i_cur;

        o_sel.up_move    = better(i_cur, i_left, i_max_mode);
        o_sel.down_right = i_right_ok && better(i_right, w_best, i_max_mode);
        o_sel.down_move  = w_left_wins || o_sel.down_right;
    end

endmodule

// ----- rtl/core/hpq_checker.sv -----
// Port-level checks for the heap priority queue core, bound into the core module.
module hpq_checker
    import hpq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [VALUE_WIDTH-1:0] o_top_value,
    input logic                   o_is_empty,
    input logic [CW-1:0]          o_entry_count,
    input logic [1:0]             o_status
);

    // a stalled result transaction holds its top value, count and status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_top_value) && $stable(o_entry_count)
            && $stable(o_status))
        else $error("result changed while stalled");

    // an accepted command makes the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("command accepted back to back");

    // empty heap reports all ones and a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_top_value == '1 && o_entry_count == '0)
        else $error("empty result inconsistent");

    // a dropped insert only happens at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == CW'(CAPACITY))
        else $error("full status below capacity");

    // a delete on empty leaves the heap empty
    a_del_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_is_empty)
        else $error("delete-on-empty status with entries");

endmodule

bind binary_heap_priority_queue_core hpq_checker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_hpq_checker (.*);
